// ===== rtl/core/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants for the MT19937 generator: table geometry, twist and
// tempering masks, seeding multiplier.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned FAR_WRAP     = STATE_WORDS - TWIST_OFFSET;
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd69069;
    localparam logic [31:0] SEED_RESET   = 32'd4357;
    localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;
    localparam logic [31:0] LSB_MASK     = 32'h0000_0001;

    typedef logic [IDX_W-1:0] t_idx;

endpackage

// ===== rtl/core/mtg_temper.sv =====
// ----------------------------------------------------------------------------
// mtg_temper
// MT19937 output tempering: two shift-xor and two shift-mask-xor steps.
// ----------------------------------------------------------------------------
module mtg_temper
    import mtg_pkg::*;
(
    input  logic [31:0] i_word,
    output logic [31:0] o_word
);

    logic [31:0] y1;
    logic [31:0] y2;
    logic [31:0] y3;

    always_comb begin
        y1     = i_word ^ (i_word >> 11);
        y2     = y1 ^ ((y1 << 7) & TEMPER_B);
        y3     = y2 ^ ((y2 << 15) & TEMPER_C);
        o_word = y3 ^ (y3 >> 18);
    end

endmodule

// ===== rtl/core/mersenne_twister_generator_top.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// MT19937 generator, one tempered word per input item. The state table
// sits in a 624x32 memory with two registered read ports and one write port.
//
//   channel   dir  handshake            payload
//   s (req)   in   i_s_tvalid/o_s_tready i_s_tdata[0] = restart
//   m (word)  out  o_m_tvalid/i_m_tready o_m_tdata[31:0] = random_word
//   seed cfg  in   i_seed_we            i_seed_data[31:0] = seed_value
//
// A normal draw accepts the request and reads the table, then twists,
// writes back and tempers into the output register.
// Seeding (first request after reset, or restart) walks the table one
// word per cycle through the 32x32 multiplier, then goes through the
// table read state and the twist state.
// Reset is synchronous, active low; the table itself is not cleared.
// A full output register with i_m_tready low holds the draw in its last cycle.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top
    import mtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] restart, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] random_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_READ,
        S_CALC
    } t_state;

    t_state      r_state;
    logic [31:0] r_seed;
    logic        r_seeded;
    t_idx        r_pos;
    t_idx        r_cnt;
    logic [31:0] r_x;
    logic [31:0] r_cur;
    logic [31:0] r_lo;
    logic [31:0] r_far;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic [31:0] mem [STATE_WORDS];

    logic        s_acc;
    logic        need_seed;
    logic        rd_en;
    t_idx        nxt_idx;
    t_idx        far_idx;
    t_idx        pos_inc;
    logic        calc_go;
    logic [31:0] mix;
    logic [31:0] twisted;
    logic [31:0] tempered;
    logic        we;
    t_idx        waddr;
    logic [31:0] wdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign need_seed = !r_seeded || i_s_tdata[0];
    assign rd_en     = (s_acc && !need_seed) || (r_state == S_READ);

    always_comb begin
        pos_inc = (r_pos == t_idx'(STATE_WORDS - 1)) ? '0 : r_pos + t_idx'(1);
        nxt_idx = pos_inc;
        far_idx = (r_pos >= t_idx'(FAR_WRAP)) ? r_pos - t_idx'(FAR_WRAP)
                                               : r_pos + t_idx'(TWIST_OFFSET);
    end

    // r_cur holds table[pos]; it was read as the neighbor word one draw earlier
    always_comb begin
        calc_go = (r_state == S_CALC) && (!r_out_valid || i_m_tready);
        mix     = (r_cur & UPPER_MASK) | (r_lo & LOWER_MASK);
        twisted = r_far ^ (mix >> 1) ^ (((r_lo & LSB_MASK) != '0) ? TWIST_MATRIX : '0);
    end

    mtg_temper u_temper (
        .i_word (twisted),
        .o_word (tempered)
    );

    always_comb begin
        we    = (r_state == S_SEED) || calc_go;
        waddr = (r_state == S_SEED) ? r_cnt : r_pos;
        wdata = (r_state == S_SEED) ? r_x : twisted;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_lo  <= mem[nxt_idx];
            r_far <= mem[far_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_seeded    <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed_data;
            end
            if (calc_go) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (need_seed) begin
                            r_state <= S_SEED;
                            r_cnt   <= '0;
                            r_x     <= r_seed | LSB_MASK;
                            r_cur   <= r_seed | LSB_MASK;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_SEED: begin
                    r_x   <= r_x * SEED_MULT;
                    r_cnt <= r_cnt + t_idx'(1);
                    if (r_cnt == t_idx'(STATE_WORDS - 1)) begin
                        r_state  <= S_READ;
                        r_seeded <= 1'b1;
                        r_pos    <= '0;
                    end
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (calc_go) begin
                        r_out       <= tempered;
                        r_cur       <= r_lo;
                        r_pos       <= pos_inc;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < t_idx'(STATE_WORDS))
        else $error("read position out of range");

    a_out_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_CALC))
        else $error("result loaded outside the twist step");

    a_read_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CALC) |-> r_seeded)
        else $error("draw started on an unseeded table");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (nxt_idx != r_pos && far_idx != r_pos))
        else $error("read address collides with the word being twisted");

endmodule
